/* src/pfla_pkg.sv */
// Shared widths, codes and helpers for the page free-list allocator.
`timescale 1ns / 1ps
`default_nettype none
package pfla_pkg;

  // Field widths fixed by the external interface
  localparam int PAGE_W   = 10;
  localparam int TABLE_W  = 3;
  localparam int EXT_W    = 5;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  // Default sizing of the page stores
  localparam int NUM_TABLES_DEF      = 8;
  localparam int PAGES_PER_TABLE_DEF = 1024;

  // Extension count register: reset value and legal range
  localparam logic [EXT_W-1:0] EXT_RESET = 5'd10;
  localparam logic [EXT_W-1:0] EXT_MIN   = 5'd1;
  localparam logic [EXT_W-1:0] EXT_MAX   = 5'd16;

  // Register index of the extension count (word address bit)
  localparam logic [0:0] REG_EXTEND_COUNT = 1'b0;

  // Operation codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_ROOM  = 2'd1,
    ST_BAD_PAGE = 2'd2
  } status_t;

  // Clamp the programmed extension count into its legal range
  function automatic logic [EXT_W-1:0] ext_clamp(input logic [EXT_W-1:0] val);
    logic [EXT_W-1:0] res;
    res = val;
    if (val < EXT_MIN) begin
      res = EXT_MIN;
    end else if (val > EXT_MAX) begin
      res = EXT_MAX;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* src/pfla_link_ram.sv */
// Next-link store: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module pfla_link_ram #(
  parameter int AW = 13,
  parameter int DW = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  localparam int DEPTH = 2 ** AW;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // Write the addressed entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* src/page_free_list_allocator_core.sv */
// Top level of the page free-list allocator: control, list heads, counts and register port.
`timescale 1ns / 1ps
`default_nettype none
// Usage
//   Command channel: an operation is taken at a rising edge where start is high and
//   busy is low. in_func selects allocate or free, in_table_req the table and in_page
//   the page to free. Exactly one result follows per operation: out_valid is high for
//   one cycle with out_alloc_page and out_status; the receiver cannot stall it.
//   Timing: a pop from a non-empty list, a free or a rejected operation passes S_EXEC
//   and shows its result from the output register; the next one may start in that cycle.
//   An allocate that finds its list empty writes the new chain one link per cycle in
//   S_EXTEND (extend_count links, clamped to 1..16) before its result. The single write
//   port of the link memory sets this pace; the head-link read is issued at the
//   transfer edge and returns in the following cycle.
//   Operations run one at a time, so link accesses never overlap. Register port:
//   extend_count at byte address 0; the user must write it only while idle (not enforced).
//   Reset (rst_n low, synchronous): all lists empty, one page (the header) per table,
//   extend_count back to 10, no result pending. The link memory is not cleared; only
//   links written by an extension or a free are ever read.
module page_free_list_allocator_core #(
  parameter int NUM_TABLES      = pfla_pkg::NUM_TABLES_DEF,
  parameter int PAGES_PER_TABLE = pfla_pkg::PAGES_PER_TABLE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pfla_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [pfla_pkg::DATA_W-1:0]   pwdata,
  output logic      [pfla_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  // command channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_func,
  input  wire logic [pfla_pkg::TABLE_W-1:0]  in_table_req,
  input  wire logic [pfla_pkg::PAGE_W-1:0]   in_page,
  // result channel
  output logic                               out_valid,
  output logic      [pfla_pkg::PAGE_W-1:0]   out_alloc_page,
  output logic      [pfla_pkg::STATUS_W-1:0] out_status
);

  localparam int TW    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int TBL_N = 2 ** TW;
  localparam int PGW   = $clog2(PAGES_PER_TABLE);
  localparam int CNTW  = $clog2(PAGES_PER_TABLE + 1);
  localparam int AW    = TW + PGW;
  localparam int TXW   = (TW > pfla_pkg::TABLE_W) ? TW : pfla_pkg::TABLE_W;
  localparam int CW    = (CNTW > pfla_pkg::PAGE_W) ? CNTW : pfla_pkg::PAGE_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_EXTEND
  } state_t;

  // Configuration register
  logic [pfla_pkg::EXT_W-1:0] extend_count_r;
  logic                       cfg_wr;
  logic                       cfg_hit;

  // Per-table list heads and page counts
  logic [PGW-1:0]  free_head_r [TBL_N];
  logic [CNTW-1:0] in_use_r    [TBL_N];
  logic            head_we;
  logic [PGW-1:0]  head_wdata;
  logic            cnt_we;
  logic [CNTW-1:0] cnt_wdata;

  // Sequencer state and captured operation
  state_t                        state_r, state_nxt;
  logic                          func_r, func_nxt;
  logic                          tbl_ok_r, tbl_ok_nxt;
  logic [TW-1:0]                 tbl_r, tbl_nxt;
  logic [pfla_pkg::PAGE_W-1:0]   page_r, page_nxt;
  logic [PGW-1:0]                hd_r, hd_nxt;
  logic [CNTW-1:0]               cnt_r, cnt_nxt;
  logic [PGW-1:0]                cur_r, cur_nxt;
  logic [pfla_pkg::EXT_W-1:0]    rem_r, rem_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [pfla_pkg::PAGE_W-1:0]   out_page_r, out_page_nxt;
  pfla_pkg::status_t             out_status_r, out_status_nxt;

  // Link memory ports
  logic           link_we;
  logic [AW-1:0]  link_waddr;
  logic [PGW-1:0] link_wdata;
  logic [AW-1:0]  link_raddr;
  logic [PGW-1:0] link_rdata;

  // Decode helpers
  logic                       accept;
  logic [TXW-1:0]             in_tbl_wide;
  logic [TW-1:0]              in_tbl;
  logic                       in_tbl_ok;
  logic [pfla_pkg::EXT_W-1:0] ext_n;
  logic [CNTW:0]              ext_sum;
  logic [CW-1:0]              page_wide;
  logic [PGW-1:0]             page_int;
  logic                       page_ok;
  logic [PGW-1:0]             first_pg;
  logic [CW-1:0]              hd_wide;
  logic [CW-1:0]              first_wide;

  // Register port: always ready, extend_count at word 0
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_hit = (paddr[pfla_pkg::ADDR_W-1:2] == pfla_pkg::REG_EXTEND_COUNT);
  assign prdata  = cfg_hit ? pfla_pkg::DATA_W'(extend_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      extend_count_r <= pfla_pkg::EXT_RESET;
    end else if (cfg_wr && cfg_hit) begin
      extend_count_r <= pwdata[pfla_pkg::EXT_W-1:0];
    end
  end

  // Command decode
  assign busy        = (state_r != S_IDLE);
  assign accept      = start && !busy;
  assign in_tbl_wide = TXW'(in_table_req);
  assign in_tbl      = in_tbl_wide[TW-1:0];
  assign in_tbl_ok   = (32'(in_table_req) < NUM_TABLES);

  // Fetch the head's link at the transfer edge
  assign link_raddr = {in_tbl, free_head_r[in_tbl]};

  pfla_link_ram #(
    .AW (AW),
    .DW (PGW)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (accept),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  // Operand preparation
  assign ext_n      = pfla_pkg::ext_clamp(extend_count_r);
  assign ext_sum    = (CNTW + 1)'(cnt_r) + (CNTW + 1)'(ext_n);
  assign page_wide  = CW'(page_r);
  assign page_int   = page_wide[PGW-1:0];
  assign page_ok    = (page_r != '0) && (page_wide < CW'(cnt_r));
  assign first_pg   = cnt_r[PGW-1:0];
  assign hd_wide    = CW'(hd_r);
  assign first_wide = CW'(first_pg);

  // Sequencer: decide, pop, push or extend
  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    tbl_ok_nxt     = tbl_ok_r;
    tbl_nxt        = tbl_r;
    page_nxt       = page_r;
    hd_nxt         = hd_r;
    cnt_nxt        = cnt_r;
    cur_nxt        = cur_r;
    rem_nxt        = rem_r;
    out_valid_nxt  = 1'b0;
    out_page_nxt   = out_page_r;
    out_status_nxt = out_status_r;
    link_we        = 1'b0;
    link_waddr     = {tbl_r, cur_r};
    link_wdata     = '0;
    head_we        = 1'b0;
    head_wdata     = '0;
    cnt_we         = 1'b0;
    cnt_wdata      = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_nxt   = in_func;
          tbl_nxt    = in_tbl;
          tbl_ok_nxt = in_tbl_ok;
          page_nxt   = in_page;
          hd_nxt     = free_head_r[in_tbl];
          cnt_nxt    = in_use_r[in_tbl];
          state_nxt  = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_page_nxt  = '0;
        if (!tbl_ok_r) begin
          // reject an out-of-range table
          out_status_nxt = (func_r == pfla_pkg::FUNC_FREE) ? pfla_pkg::ST_BAD_PAGE
                                                           : pfla_pkg::ST_NO_ROOM;
        end else if (func_r == pfla_pkg::FUNC_ALLOC) begin
          if (hd_r != '0) begin
            // pop the head, its link becomes the new head
            head_we        = 1'b1;
            head_wdata     = link_rdata;
            out_page_nxt   = hd_wide[pfla_pkg::PAGE_W-1:0];
            out_status_nxt = pfla_pkg::ST_OK;
          end else if (ext_sum > (CNTW + 1)'(PAGES_PER_TABLE)) begin
            // table full: drop the request
            out_status_nxt = pfla_pkg::ST_NO_ROOM;
          end else begin
            // chain new pages first
            state_nxt     = S_EXTEND;
            out_valid_nxt = 1'b0;
            cur_nxt       = first_pg;
            rem_nxt       = ext_n;
          end
        end else if (page_ok) begin
          // push the page on the head
          link_we        = 1'b1;
          link_waddr     = {tbl_r, page_int};
          link_wdata     = hd_r;
          head_we        = 1'b1;
          head_wdata     = page_int;
          out_status_nxt = pfla_pkg::ST_OK;
        end else begin
          out_status_nxt = pfla_pkg::ST_BAD_PAGE;
        end
      end

      S_EXTEND: begin
        // write one link per cycle, last one terminates the chain
        link_we    = 1'b1;
        link_waddr = {tbl_r, cur_r};
        link_wdata = (rem_r == pfla_pkg::EXT_W'(1)) ? '0 : PGW'(cur_r + 1'b1);
        cur_nxt    = PGW'(cur_r + 1'b1);
        rem_nxt    = rem_r - 1'b1;
        if (rem_r == pfla_pkg::EXT_W'(1)) begin
          // hand out the first new page, the rest form the list
          cnt_we         = 1'b1;
          cnt_wdata      = CNTW'(cur_r) + 1'b1;
          head_we        = 1'b1;
          head_wdata     = (cur_r == first_pg) ? '0 : PGW'(first_pg + 1'b1);
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_page_nxt   = first_wide[pfla_pkg::PAGE_W-1:0];
          out_status_nxt = pfla_pkg::ST_OK;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      out_page_r   <= '0;
      out_status_r <= pfla_pkg::ST_OK;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      out_page_r   <= out_page_nxt;
      out_status_r <= out_status_nxt;
    end
    func_r   <= func_nxt;
    tbl_ok_r <= tbl_ok_nxt;
    tbl_r    <= tbl_nxt;
    page_r   <= page_nxt;
    hd_r     <= hd_nxt;
    cnt_r    <= cnt_nxt;
    cur_r    <= cur_nxt;
    rem_r    <= rem_nxt;
  end

  // Update list heads and page counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TBL_N; i++) begin
        free_head_r[i] <= '0;
        in_use_r[i]    <= CNTW'(1);
      end
    end else begin
      if (head_we) begin
        free_head_r[tbl_r] <= head_wdata;
      end
      if (cnt_we) begin
        in_use_r[tbl_r] <= cnt_wdata;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_alloc_page = out_page_r;
  assign out_status     = out_status_r;

`ifndef SYNTH
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result transfer while an operation is in progress");

  a_error_no_page: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != pfla_pkg::ST_OK) |-> (out_alloc_page == '0))
    else $error("error result carries a page number");

  a_no_room_is_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == pfla_pkg::ST_NO_ROOM) |-> (func_r == pfla_pkg::FUNC_ALLOC))
    else $error("capacity error reported for a free");

  a_bad_page_is_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == pfla_pkg::ST_BAD_PAGE) |-> (func_r == pfla_pkg::FUNC_FREE))
    else $error("invalid-page error reported for an allocate");

  a_extend_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXTEND) |-> (rem_r != '0 && rem_r <= pfla_pkg::EXT_MAX))
    else $error("extension counter out of range");
`endif

endmodule
`default_nettype wire

/* tb/page_alloc_checker.sv */
// Checker for the page free-list allocator: predicts every transfer and compares results.
`timescale 1ns / 1ps
module page_alloc_checker
  import pfla_pkg::*;
#(
  parameter int NUM_TABLES      = NUM_TABLES_DEF,
  parameter int PAGES_PER_TABLE = PAGES_PER_TABLE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  input  logic [DATA_W-1:0]   prdata,
  input  logic                pready,
  // command and result channels
  input  logic                start,
  input  logic                busy,
  input  logic                in_func,
  input  logic [TABLE_W-1:0]  in_table_req,
  input  logic [PAGE_W-1:0]   in_page,
  input  logic                out_valid,
  input  logic [PAGE_W-1:0]   out_alloc_page,
  input  logic [STATUS_W-1:0] out_status,
  // outcome
  output int                  fail_count,
  output int                  pending,
  output int                  n_ok,
  output int                  n_no_room,
  output int                  n_bad_page
);

  localparam logic [ADDR_W-1:0] ADDR_EXTEND = {REG_EXTEND_COUNT, 2'b00};

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    status_t           status;
  } page_result_t;

  // Shadow copy of the allocator state
  logic [EXT_W-1:0]  ext_reg;
  logic [PAGE_W-1:0] list_head  [NUM_TABLES];
  logic [PAGE_W:0]   pages_made [NUM_TABLES];
  logic [PAGE_W-1:0] link_mem   [NUM_TABLES][PAGES_PER_TABLE];

  page_result_t awaited_results[$];

  task automatic clear_lists();
    ext_reg = EXT_RESET;
    for (int t = 0; t < NUM_TABLES; t++) begin
      list_head[t]  = '0;
      pages_made[t] = (PAGE_W + 1)'(1);
    end
    awaited_results.delete();
  endtask

  // Work out the result of one operation and advance the shadow lists
  task automatic predict_page_op(input logic func, input logic [TABLE_W-1:0] tbl,
                                 input logic [PAGE_W-1:0] pg);
    page_result_t r;
    int t;
    int n;
    int first;
    int head;
    r.page   = '0;
    r.status = ST_OK;
    t = tbl;
    if (t >= NUM_TABLES) begin
      r.status = (func == FUNC_FREE) ? ST_BAD_PAGE : ST_NO_ROOM;
    end else if (func == FUNC_ALLOC) begin
      head = list_head[t];
      // empty list: chain a fresh run of pages first, unless the table is full
      if (head == 0) begin
        n = ext_reg;
        if (n < EXT_MIN) n = EXT_MIN;
        if (n > EXT_MAX) n = EXT_MAX;
        first = pages_made[t];
        if (first + n > PAGES_PER_TABLE) begin
          r.status = ST_NO_ROOM;
        end else begin
          for (int i = 0; i < n; i++) begin
            link_mem[t][first + i] = (i == n - 1) ? '0 : PAGE_W'(first + i + 1);
          end
          pages_made[t] = (PAGE_W + 1)'(first + n);
          head = first;
        end
      end
      if (r.status == ST_OK) begin
        r.page       = PAGE_W'(head);
        list_head[t] = link_mem[t][head];
      end
    end else begin
      // free: reject the header page and pages never created, else push
      if (pg == 0 || pg >= pages_made[t]) begin
        r.status = ST_BAD_PAGE;
      end else begin
        link_mem[t][pg] = list_head[t];
        list_head[t]    = pg;
      end
    end
    awaited_results.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    page_result_t want;
    if (!rst_n) begin
      clear_lists();
    end else begin
      // compare a result transfer with the oldest prediction
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          $error("result with nothing outstanding: alloc_page %0d status %0d",
                 out_alloc_page, out_status);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_alloc_page !== want.page) begin
            $error("alloc_page: expected %0d, got %0d", want.page, out_alloc_page);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fail_count++;
          end
          case (want.status)
            ST_OK:      n_ok++;
            ST_NO_ROOM: n_no_room++;
            default:    n_bad_page++;
          endcase
        end
      end
      // track register writes and check read data
      if (psel && penable && pready && paddr == ADDR_EXTEND) begin
        if (pwrite) begin
          ext_reg = pwdata[EXT_W-1:0];
        end else if (prdata[EXT_W-1:0] !== ext_reg) begin
          $error("extend_count: expected %0d, got %0d", ext_reg, prdata[EXT_W-1:0]);
          fail_count++;
        end
      end
      // predict the operation taken at this edge
      if (start && !busy) begin
        predict_page_op(in_func, in_table_req, in_page);
      end
    end
    pending = awaited_results.size();
  end

endmodule

/* tb/page_free_list_allocator_core_tb.sv */
// Testbench top for the page free-list allocator: stimulus, register sweeps and verdict.
`timescale 1ns / 1ps
module page_free_list_allocator_core_tb;
  import pfla_pkg::*;

  localparam logic [ADDR_W-1:0] ADDR_EXTEND = {REG_EXTEND_COUNT, 2'b00};
  // settle time covers the longest operation, an extension of EXT_MAX links
  localparam int SETTLE_CYCLES = 24;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [ADDR_W-1:0]   paddr        = '0;
  logic [DATA_W-1:0]   pwdata       = '0;
  logic                start        = 1'b0;
  logic                in_func      = FUNC_ALLOC;
  logic [TABLE_W-1:0]  in_table_req = '0;
  logic [PAGE_W-1:0]   in_page      = '0;
  wire  [DATA_W-1:0]   prdata;
  wire                 pready;
  wire                 busy;
  wire                 out_valid;
  wire  [PAGE_W-1:0]   out_alloc_page;
  wire  [STATUS_W-1:0] out_status;

  int fail_count;
  int pending;
  int n_ok;
  int n_no_room;
  int n_bad_page;
  int ops_sent   = 0;
  int cfg_writes = 0;
  bit gaps_on    = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  page_free_list_allocator_core u_dut (
    .clk, .rst_n,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .in_func, .in_table_req, .in_page,
    .out_valid, .out_alloc_page, .out_status
  );

  page_alloc_checker u_checker (
    .clk, .rst_n,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .in_func, .in_table_req, .in_page,
    .out_valid, .out_alloc_page, .out_status,
    .fail_count, .pending, .n_ok, .n_no_room, .n_bad_page
  );

  // Present one operation and hold it until the transfer
  task automatic issue(input logic f, input logic [TABLE_W-1:0] t, input logic [PAGE_W-1:0] p);
    if (gaps_on && $urandom_range(99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start        <= 1'b1;
    in_func      <= f;
    in_table_req <= t;
    in_page      <= p;
    do @(posedge clk); while (busy);
    ops_sent++;
  endtask

  // Hold the sender until every result is back and the block is quiet
  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_access(input logic wr, input logic [DATA_W-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_EXTEND;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Program extend_count with noise in the unused upper bits, then read it back
  task automatic set_extend(input logic [EXT_W-1:0] val);
    logic [DATA_W-1:0] word;
    word = $urandom;
    word[EXT_W-1:0] = val;
    drain();
    reg_access(1'b1, word);
    reg_access(1'b0, '0);
    cfg_writes++;
  endtask

  // Random mix: slightly more allocates than frees, pages mostly 1..63, plus full-range noise
  task automatic mixed_burst(input int count, input int hot);
    logic              f;
    logic [TABLE_W-1:0] t;
    logic [PAGE_W-1:0]  p;
    int                roll;
    for (int k = 0; k < count; k++) begin
      f    = ($urandom_range(99) < 55) ? FUNC_ALLOC : FUNC_FREE;
      t    = TABLE_W'($urandom_range(hot - 1));
      roll = $urandom_range(99);
      if (roll < 80) begin
        p = PAGE_W'($urandom_range(1, 63));
      end else if (roll < 90) begin
        p = PAGE_W'($urandom);
      end else begin
        p = PAGE_W'($urandom_range(0, 15));
      end
      issue(f, t, p);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // confirm the reset value of extend_count
    reg_access(1'b0, '0);

    // Directed: bad frees, first extension, push and pop, double free, every table
    issue(FUNC_FREE,  3'd0, 10'd0);
    issue(FUNC_FREE,  3'd0, 10'd1);
    issue(FUNC_ALLOC, 3'd0, 10'h3FF);
    issue(FUNC_ALLOC, 3'd0, 10'd0);
    issue(FUNC_FREE,  3'd0, 10'd1023);
    issue(FUNC_FREE,  3'd0, 10'd11);
    issue(FUNC_FREE,  3'd0, 10'd1);
    issue(FUNC_ALLOC, 3'd0, 10'd0);
    issue(FUNC_FREE,  3'd0, 10'd10);
    issue(FUNC_FREE,  3'd0, 10'd10);
    issue(FUNC_ALLOC, 3'd0, 10'd0);
    issue(FUNC_ALLOC, 3'd0, 10'd0);
    issue(FUNC_ALLOC, 3'd0, 10'd0);
    issue(FUNC_FREE,  3'd1, 10'h2AA);
    issue(FUNC_FREE,  3'd2, 10'h155);
    for (int t = 1; t < 8; t++) begin
      issue(FUNC_ALLOC, TABLE_W'(t), 10'd0);
    end
    issue(FUNC_FREE,  3'd5, 10'd1);
    issue(FUNC_FREE,  3'd7, 10'd1023);

    // Long stretch with no idling at the largest extension step
    set_extend(EXT_MAX);
    gaps_on = 1'b0;
    mixed_burst(170, 8);
    gaps_on = 1'b1;

    // Single-page extensions on table 7, then reuse freed pages
    set_extend(EXT_MIN);
    for (int k = 0; k < 10; k++) begin
      issue(FUNC_ALLOC, 3'd7, 10'd0);
    end
    issue(FUNC_FREE,  3'd7, 10'd1023);
    issue(FUNC_FREE,  3'd7, 10'd512);
    issue(FUNC_FREE,  3'd7, 10'd1);
    for (int k = 0; k < 4; k++) begin
      issue(FUNC_ALLOC, 3'd7, 10'd0);
    end

    // Random phases across clamped, extreme and random settings
    set_extend(5'd0);
    mixed_burst(85, 2);
    drain();
    mixed_burst(85, 2);
    set_extend(5'd31);
    mixed_burst(130, 8);
    set_extend(EXT_MIN);
    mixed_burst(130, 4);
    set_extend(5'd17);
    mixed_burst(130, 8);
    set_extend(EXT_W'($urandom_range(0, 31)));
    mixed_burst(80, 8);

    // Wait for the last results, then give the verdict
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d operations over %0d extend_count settings (clamped values included).",
             ops_sent, cfg_writes);
    $display("Results: %0d ok, %0d out of capacity, %0d invalid free.",
             n_ok, n_no_room, n_bad_page);
    if (fail_count == 0) begin
      $display("page_free_list_allocator_core verification clean");
    end else begin
      $display("page_free_list_allocator_core verification failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("page_free_list_allocator_core verification failed");
    $finish;
  end

endmodule
